// ===== src/ovle_pkg.sv =====
// ----------------------------------------------------------------------------
// ovle_pkg
// Shared types and constants of the ordered value list engine: field widths,
// operation and status codes, controller states and the command and status
// bundles between controller and datapath.
// ----------------------------------------------------------------------------
package ovle_pkg;

	localparam int CAPACITY_DEF = 16;

	localparam int OPCODE_W  = 2;
	localparam int VALUE_W   = 32;
	localparam int STATUS_W  = 2;
	localparam int INDEX_W   = 4;
	localparam int COUNT_W   = 5;
	localparam int S_TDATA_W = 64;
	localparam int M_TDATA_W = 16;

	typedef enum logic [OPCODE_W-1:0] {
		OP_APPEND = 2'd0,
		OP_REMOVE = 2'd1,
		OP_SEARCH = 2'd2,
		OP_UPDATE = 2'd3
	} opcode_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK        = 2'd0,
		STAT_NOT_FOUND = 2'd1,
		STAT_EMPTY     = 2'd2,
		STAT_FULL      = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_SCAN,
		S_SHIFT,
		S_FINISH
	} state_t;

	// read address select: first entry, next after pointer, two after pointer
	typedef enum logic [1:0] {
		RD_FIRST,
		RD_NEXT,
		RD_SKIP
	} rd_mode_t;

	typedef struct packed {
		logic     capture;
		logic     rd_en;
		rd_mode_t rd_mode;
		logic     ptr_clr;
		logic     ptr_inc;
		logic     append_wr;
		logic     update_wr;
		logic     shift_wr;
		logic     dec_count;
		logic     set_status;
		status_t  status;
		logic     set_index;
		logic     load_out;
	} ovle_cmd_t;

	typedef struct packed {
		opcode_t op;
		logic    empty;
		logic    full;
		logic    match;
		logic    scan_last;
		logic    out_busy;
	} ovle_stat_t;

endpackage

// ===== src/ovle_ctrl.sv =====
// ----------------------------------------------------------------------------
// ovle_ctrl
// Controller state machine: takes an item, steps the datapath through the
// check, the scan for a first match and the compaction shift, then hands
// the result to the output register.
// ----------------------------------------------------------------------------
module ovle_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  ovle_pkg::ovle_stat_t   stat,
	output ovle_pkg::ovle_cmd_t    cmd
);
	import ovle_pkg::*;

	state_t state_q;
	state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_next = S_CHECK;
				end
			end
			S_CHECK: begin
				if (stat.op == OP_APPEND || stat.empty) begin
					state_next = S_FINISH;
				end else begin
					state_next = S_SCAN;
				end
			end
			S_SCAN: begin
				if (stat.match) begin
					state_next = (stat.op == OP_REMOVE) ? S_SHIFT : S_FINISH;
				end else if (stat.scan_last) begin
					state_next = S_FINISH;
				end
			end
			S_SHIFT: begin
				if (stat.scan_last) begin
					state_next = S_FINISH;
				end
			end
			S_FINISH: begin
				if (!stat.out_busy) begin
					state_next = S_IDLE;
				end
			end
			default: begin
				state_next = S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.rd_mode = RD_FIRST;
		cmd.status = STAT_OK;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.capture = in_valid;
			end
			S_CHECK: begin
				if (stat.op == OP_APPEND) begin
					cmd.set_status = 1'b1;
					if (stat.full) begin
						cmd.status = STAT_FULL;
					end else begin
						cmd.append_wr = 1'b1;
					end
				end else if (stat.empty) begin
					cmd.set_status = 1'b1;
					cmd.status = STAT_EMPTY;
				end else begin
					cmd.rd_en = 1'b1;
					cmd.rd_mode = RD_FIRST;
					cmd.ptr_clr = 1'b1;
				end
			end
			S_SCAN: begin
				if (stat.match) begin
					cmd.set_status = 1'b1;
					case (stat.op)
						OP_SEARCH: cmd.set_index = 1'b1;
						OP_UPDATE: cmd.update_wr = 1'b1;
						OP_REMOVE: begin
							// fetch the entry after the match for the first shift
							cmd.rd_en = 1'b1;
							cmd.rd_mode = RD_NEXT;
						end
						default: cmd.set_status = 1'b1;
					endcase
				end else if (stat.scan_last) begin
					cmd.set_status = 1'b1;
					cmd.status = STAT_NOT_FOUND;
				end else begin
					cmd.rd_en = 1'b1;
					cmd.rd_mode = RD_NEXT;
					cmd.ptr_inc = 1'b1;
				end
			end
			S_SHIFT: begin
				if (stat.scan_last) begin
					cmd.dec_count = 1'b1;
				end else begin
					cmd.shift_wr = 1'b1;
					cmd.rd_en = 1'b1;
					cmd.rd_mode = RD_SKIP;
					cmd.ptr_inc = 1'b1;
				end
			end
			S_FINISH: begin
				cmd.load_out = !stat.out_busy;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

// ===== src/ovle_dp.sv =====
// ----------------------------------------------------------------------------
// ovle_dp
// Datapath: entry memory with registered read, entry count, scan pointer,
// comparator, result registers and the output register.
// ----------------------------------------------------------------------------
module ovle_dp #(
	parameter int CAPACITY = ovle_pkg::CAPACITY_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  ovle_pkg::opcode_t                in_opcode,
	input  logic [ovle_pkg::VALUE_W-1:0]     in_value,
	input  logic [ovle_pkg::VALUE_W-1:0]     in_new_value,
	input  ovle_pkg::ovle_cmd_t              cmd,
	output ovle_pkg::ovle_stat_t             stat,
	output logic                             out_valid,
	input  logic                             out_ready,
	output ovle_pkg::status_t                out_status,
	output logic [ovle_pkg::INDEX_W-1:0]     out_found_index,
	output logic [ovle_pkg::COUNT_W-1:0]     out_entry_count
);
	import ovle_pkg::*;

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic [VALUE_W-1:0] mem [CAPACITY];

	opcode_t            op_q;
	logic [VALUE_W-1:0] value_q;
	logic [VALUE_W-1:0] new_value_q;
	logic [CNT_W-1:0]   count_q;
	logic [IDX_W-1:0]   ptr_q;
	logic [VALUE_W-1:0] rd_data_q;
	status_t            res_status_q;
	logic [IDX_W-1:0]   res_index_q;
	logic               out_valid_q;
	status_t            out_status_q;
	logic [INDEX_W-1:0] out_index_q;
	logic [COUNT_W-1:0] out_count_q;

	logic [IDX_W:0]         rd_addr_wide;
	logic [IDX_W-1:0]       rd_addr;
	logic                   wr_en;
	logic [IDX_W-1:0]       wr_addr;
	logic [VALUE_W-1:0]     wr_data;
	logic [IDX_W+INDEX_W-1:0] index_ext;
	logic [CNT_W+COUNT_W-1:0] count_ext;

	always_comb begin
		case (cmd.rd_mode)
			RD_FIRST: rd_addr_wide = '0;
			RD_NEXT:  rd_addr_wide = {1'b0, ptr_q} + (IDX_W+1)'(1);
			RD_SKIP:  rd_addr_wide = {1'b0, ptr_q} + (IDX_W+1)'(2);
			default:  rd_addr_wide = '0;
		endcase
	end
	assign rd_addr = rd_addr_wide[IDX_W-1:0];

	assign wr_en = cmd.append_wr | cmd.update_wr | cmd.shift_wr;

	always_comb begin
		if (cmd.append_wr) begin
			wr_addr = count_q[IDX_W-1:0];
			wr_data = value_q;
		end else if (cmd.update_wr) begin
			wr_addr = ptr_q;
			wr_data = new_value_q;
		end else begin
			// shift moves the entry after the pointer down onto it
			wr_addr = ptr_q;
			wr_data = rd_data_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q <= in_opcode;
			value_q <= in_value;
			new_value_q <= in_new_value;
		end
		if (cmd.ptr_clr) begin
			ptr_q <= '0;
		end else if (cmd.ptr_inc) begin
			ptr_q <= ptr_q + IDX_W'(1);
		end
		if (cmd.capture) begin
			res_index_q <= '0;
		end else if (cmd.set_index) begin
			res_index_q <= ptr_q;
		end
		if (cmd.set_status) begin
			res_status_q <= cmd.status;
		end
		if (cmd.load_out) begin
			out_status_q <= res_status_q;
			out_index_q <= index_ext[INDEX_W-1:0];
			out_count_q <= count_ext[COUNT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.append_wr) begin
				count_q <= count_q + CNT_W'(1);
			end else if (cmd.dec_count) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// positions wider than the result fields are masked to their widths
	assign index_ext = {{INDEX_W{1'b0}}, res_index_q};
	assign count_ext = {{COUNT_W{1'b0}}, count_q};

	assign stat.op = op_q;
	assign stat.empty = (count_q == '0);
	assign stat.full = (count_q == CNT_W'(CAPACITY));
	assign stat.match = (rd_data_q == value_q);
	assign stat.scan_last = ((CNT_W'(ptr_q) + CNT_W'(1)) == count_q);
	assign stat.out_busy = out_valid_q & ~out_ready;

	assign out_valid = out_valid_q;
	assign out_status = out_status_q;
	assign out_found_index = out_index_q;
	assign out_entry_count = out_count_q;

endmodule

// ===== src/ordered_value_list_engine_top.sv =====
// Append and any item on an empty list go straight to the result; search,
// update and remove scan from the first entry up to the first match or the
// end, and remove then shifts the later entries down by one position.
// One item is in work at a time; the next is taken only after its result
// enters the output register. The scan of the entry memory, one entry a
// cycle, sets the rate. Reset clears the count; entries are not cleared.
// ----------------------------------------------------------------------------
// ordered_value_list_engine_top
// Bounded ordered list of signed 32-bit values with append, remove, search
// and update of the first match, one status result per item.
// ----------------------------------------------------------------------------
module ordered_value_list_engine_top #(
	parameter int CAPACITY = ovle_pkg::CAPACITY_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [ovle_pkg::S_TDATA_W-1:0]   s_tdata,  // value, new_value
	input  logic [ovle_pkg::OPCODE_W-1:0]    s_tuser,  // opcode
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [ovle_pkg::M_TDATA_W-1:0]   m_tdata,  // found_index, entry_count, zero fill
	output logic [ovle_pkg::STATUS_W-1:0]    m_tuser   // status
);
	import ovle_pkg::*;

	ovle_cmd_t          cmd;
	ovle_stat_t         stat;
	opcode_t            in_opcode;
	status_t            out_status;
	logic [INDEX_W-1:0] out_found_index;
	logic [COUNT_W-1:0] out_entry_count;

	assign in_opcode = opcode_t'(s_tuser);

	ovle_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	ovle_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_opcode       (in_opcode),
		.in_value        (s_tdata[VALUE_W-1:0]),
		.in_new_value    (s_tdata[2*VALUE_W-1:VALUE_W]),
		.cmd             (cmd),
		.stat            (stat),
		.out_valid       (m_tvalid),
		.out_ready       (m_tready),
		.out_status      (out_status),
		.out_found_index (out_found_index),
		.out_entry_count (out_entry_count)
	);

	assign m_tdata = {{(M_TDATA_W-INDEX_W-COUNT_W){1'b0}}, out_entry_count, out_found_index};
	assign m_tuser = out_status;

endmodule

// ===== test/ovle_list_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ovle_list_checker
// Watches both stream channels of the ordered value list engine. Every
// accepted item is run through a behavioral copy of the list to produce the
// expected status, found_index and entry_count. Every accepted result is then
// compared field by field with the oldest expected one.
// ----------------------------------------------------------------------------
module ovle_list_checker #(
	parameter int CAPACITY = ovle_pkg::CAPACITY_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	input  logic                           s_tready,
	input  logic [ovle_pkg::S_TDATA_W-1:0] s_tdata,   // value, new_value
	input  logic [ovle_pkg::OPCODE_W-1:0]  s_tuser,   // opcode
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	input  logic [ovle_pkg::M_TDATA_W-1:0] m_tdata,   // found_index, entry_count, zero fill
	input  logic [ovle_pkg::STATUS_W-1:0]  m_tuser,   // status
	output int                             mismatches,
	output int                             pending
);
	import ovle_pkg::*;

	typedef struct packed {
		status_t             status;
		logic [INDEX_W-1:0]  found_index;
		logic [COUNT_W-1:0]  entry_count;
	} list_result_t;

	logic [VALUE_W-1:0] list_entries [$];
	list_result_t       expected_results [$];

	// applies one item to the list copy and returns the status, found_index and entry_count it reports
	function automatic list_result_t predict_list_op(opcode_t op, logic [VALUE_W-1:0] v,
			logic [VALUE_W-1:0] nv);
		list_result_t res;
		int pos;
		res.status = STAT_OK;
		res.found_index = '0;
		pos = -1;
		for (int i = 0; i < list_entries.size(); i++)
			if (pos < 0 && list_entries[i] == v)
				pos = i;
		if (op == OP_APPEND) begin
			if (list_entries.size() >= CAPACITY)
				res.status = STAT_FULL;
			else
				list_entries.push_back(v);
		end else if (list_entries.size() == 0) begin
			res.status = STAT_EMPTY;
		end else if (pos < 0) begin
			res.status = STAT_NOT_FOUND;
		end else begin
			case (op)
				OP_REMOVE: list_entries.delete(pos);
				OP_SEARCH: res.found_index = pos[INDEX_W-1:0];
				default:   list_entries[pos] = nv;
			endcase
		end
		res.entry_count = COUNT_W'(list_entries.size());
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		list_result_t want;
		logic [INDEX_W-1:0] got_index;
		logic [COUNT_W-1:0] got_count;
		int errs;
		if (!arst_n) begin
			list_entries.delete();
			expected_results.delete();
			mismatches <= 0;
			pending <= 0;
		end else begin
			errs = 0;
			got_index = m_tdata[INDEX_W-1:0];
			got_count = m_tdata[INDEX_W +: COUNT_W];
			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					$error("unexpected result: status %0d found_index %0d entry_count %0d",
						m_tuser, got_index, got_count);
					errs++;
				end else begin
					want = expected_results.pop_front();
					if (m_tuser !== want.status) begin
						$error("status expected %0d actual %0d", want.status, m_tuser);
						errs++;
					end
					if (got_index !== want.found_index) begin
						$error("found_index expected %0d actual %0d", want.found_index, got_index);
						errs++;
					end
					if (got_count !== want.entry_count) begin
						$error("entry_count expected %0d actual %0d", want.entry_count, got_count);
						errs++;
					end
				end
			end
			if (s_tvalid && s_tready)
				expected_results.push_back(predict_list_op(opcode_t'(s_tuser),
					s_tdata[VALUE_W-1:0], s_tdata[2*VALUE_W-1:VALUE_W]));
			mismatches <= mismatches + errs;
			pending <= expected_results.size();
		end
	end

endmodule

// ===== test/ordered_value_list_engine_top_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ordered_value_list_engine_top_test
// Drives the list engine with a directed walk through empty, full, duplicate
// and not-found cases, then with random append, remove, search and update
// items drawn mostly from a small value pool so that matches are common.
// Both channels stall in random bursts; a separate checker predicts and
// compares every result.
// ----------------------------------------------------------------------------
module ordered_value_list_engine_top_test;
	import ovle_pkg::*;

	localparam int CAPACITY     = CAPACITY_DEF;
	localparam int RANDOM_ITEMS = 1900;
	localparam int CALM_ITEMS   = 200;
	localparam int POOL_SIZE    = 12;
	localparam int RECENT_SIZE  = 8;

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata  = '0;
	logic [OPCODE_W-1:0]  s_tuser  = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [STATUS_W-1:0]  m_tuser;
	int                   mismatches;
	int                   pending;

	logic                 calm = 1'b0;
	int                   send_idle_pct = 0;
	int                   recv_idle_pct = 0;
	int                   stall_left = 0;
	logic [VALUE_W-1:0]   value_pool [POOL_SIZE];
	logic [VALUE_W-1:0]   recent_values [RECENT_SIZE];
	int                   recent_wr = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	ordered_value_list_engine_top #(
		.CAPACITY(CAPACITY)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	ovle_list_checker #(
		.CAPACITY(CAPACITY)
	) list_checker (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.mismatches(mismatches),
		.pending(pending)
	);

	// result side back-pressure in bursts
	always @(negedge clk) begin
		if (calm || recv_idle_pct == 0) begin
			stall_left = 0;
			m_tready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if ($urandom_range(0, 99) < recv_idle_pct) begin
			stall_left = $urandom_range(1, 10) - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// mostly pool values so remove, search and update find something
	function automatic logic [VALUE_W-1:0] pick_value();
		int r;
		logic [VALUE_W-1:0] fresh;
		r = $urandom_range(0, 99);
		if (r < 65)
			return value_pool[$urandom_range(0, POOL_SIZE - 1)];
		if (r < 85)
			return recent_values[$urandom_range(0, RECENT_SIZE - 1)];
		fresh = $urandom;
		recent_values[recent_wr] = fresh;
		recent_wr = (recent_wr + 1) % RECENT_SIZE;
		return fresh;
	endfunction

	task automatic push_item(input opcode_t op, input logic [VALUE_W-1:0] v,
			input logic [VALUE_W-1:0] nv);
		int gap;
		gap = 0;
		if (!calm && send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct)
			gap = $urandom_range(1, 10);
		if (gap != 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= {nv, v};
		s_tuser  <= op;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	initial begin
		logic [VALUE_W-1:0] tail_value;
		opcode_t op;
		int append_pct;
		value_pool[0] = 32'h8000_0000;
		value_pool[1] = 32'h7FFF_FFFF;
		value_pool[2] = 32'h0000_0000;
		value_pool[3] = 32'hFFFF_FFFF;
		for (int i = 4; i < POOL_SIZE; i++)
			value_pool[i] = $urandom;
		for (int i = 0; i < RECENT_SIZE; i++)
			recent_values[i] = $urandom;
		append_pct = 50;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// empty list refuses everything but append
		push_item(OP_REMOVE, 32'h0000_0005, '0);
		push_item(OP_SEARCH, 32'h8000_0000, '0);
		push_item(OP_UPDATE, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
		// fill to capacity with extremes and a duplicate
		push_item(OP_APPEND, 32'h8000_0000, 32'hFFFF_FFFF);
		push_item(OP_APPEND, 32'h7FFF_FFFF, '0);
		push_item(OP_APPEND, 32'h0000_0000, '0);
		push_item(OP_APPEND, 32'hFFFF_FFFF, '0);
		push_item(OP_APPEND, 32'h7FFF_FFFF, '0);
		tail_value = '0;
		for (int i = 5; i < CAPACITY; i++) begin
			tail_value = $urandom;
			push_item(OP_APPEND, tail_value, $urandom);
		end
		push_item(OP_APPEND, 32'h1357_9BDF, '0);
		// duplicate hits the lower position only
		push_item(OP_SEARCH, 32'h7FFF_FFFF, '0);
		push_item(OP_SEARCH, tail_value, '0);
		push_item(OP_UPDATE, 32'h7FFF_FFFF, 32'h5555_AAAA);
		push_item(OP_SEARCH, 32'h7FFF_FFFF, '0);
		// head, tail and middle removal
		push_item(OP_REMOVE, 32'h8000_0000, '0);
		push_item(OP_REMOVE, tail_value, '0);
		push_item(OP_REMOVE, 32'h0000_0000, '0);
		push_item(OP_SEARCH, 32'h8000_0000, '0);
		push_item(OP_UPDATE, 32'h2468_ACE0, 32'hFFFF_FFFF);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			// phases lean toward filling, draining or hovering
			if (n % 100 == 0) begin
				case ($urandom_range(0, 2))
					0:       append_pct = 25;
					1:       append_pct = 50;
					default: append_pct = 80;
				endcase
				send_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
				recv_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
			end
			if (n == RANDOM_ITEMS - CALM_ITEMS)
				calm = 1'b1;
			if (n == RANDOM_ITEMS / 2)
				wait_drained();
			if ($urandom_range(0, 99) < append_pct)
				op = OP_APPEND;
			else
				op = opcode_t'($urandom_range(1, 3));
			push_item(op, pick_value(), pick_value());
		end

		wait_drained();
		repeat (2 * CAPACITY + 8) @(posedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
